/* sv/scfd_pkg.sv */
// package for the servo command frame decoder
// holds frame phase, fail cause and register index codes plus reset values
// no dependencies
package scfd_pkg;

  localparam int unsigned SERVO_COUNT = 6;

  localparam logic [7:0]  START_MARKER_RST  = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST    = 8'h55;
  localparam logic [15:0] HUNT_LIMIT_RST    = 16'd1000;
  localparam logic [7:0]  ACK_OK_RST        = 8'hAC;
  localparam logic [7:0]  ACK_FAIL_RST      = 8'hAD;
  localparam logic [15:0] MAX_ANGLE_RST     = 16'd180;
  localparam logic [7:0]  PULSE_GAIN_RST    = 8'd11;
  localparam logic [15:0] PULSE_OFFSET_RST  = 16'd500;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    PHASE_HUNT  = 3'd0,
    PHASE_SERVO = 3'd1,
    PHASE_HIGH  = 3'd2,
    PHASE_LOW   = 3'd3,
    PHASE_CHECK = 3'd4,
    PHASE_END   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_TIMEOUT   = 3'd1,
    CAUSE_BAD_END   = 3'd2,
    CAUSE_BAD_CHECK = 3'd3,
    CAUSE_RANGE     = 3'd4
  } cause_e;

  typedef enum logic [2:0] {
    REG_START_MARKER = 3'd0,
    REG_END_MARKER   = 3'd1,
    REG_HUNT_LIMIT   = 3'd2,
    REG_ACK_OK       = 3'd3,
    REG_ACK_FAIL     = 3'd4,
    REG_MAX_ANGLE    = 3'd5,
    REG_PULSE_GAIN   = 3'd6,
    REG_PULSE_OFFSET = 3'd7
  } reg_idx_e;

endpackage

/* sv/servo_command_frame_decoder_core.sv */
// servo command frame decoder top level: frame parser, checks, pulse math
// and config registers
// depends on scfd_pkg
//
// usage:
// - in channel (in_valid_i/in_ready_o, rx_byte_i) takes one received byte
//   per item; the decoder hunts for the start marker, then captures servo,
//   angle high, angle low, checksum and end byte
// - out channel (out_valid_o/out_ready_i) gives one reply item per frame
//   end byte and per hunt timeout; other bytes give no item
// - a reply item appears in the cycle after the byte that causes it is taken;
//   a byte can be taken every cycle unless a held reply is stalled
// - when the receiver stalls, a held reply keeps in_ready_o low until it
//   is taken; in_ready_o follows out_ready_i while a reply is held
// - apb port at byte address 4*i writes and reads the eight registers;
//   write only while no frame is in flight
// - reset returns all registers to their defaults, drops any held reply
//   and restarts the hunt with a zero count
module servo_command_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    reply_byte_o,
  output logic                          accepted_o,
  output logic [2:0]                    fail_cause_o,
  output logic [2:0]                    servo_index_o,
  output logic [15:0]                   pulse_width_o,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scfd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // config registers
  logic [7:0]  start_marker_q;
  logic [7:0]  end_marker_q;
  logic [15:0] hunt_limit_q;
  logic [7:0]  ack_ok_q;
  logic [7:0]  ack_fail_q;
  logic [15:0] max_angle_q;
  logic [7:0]  pulse_gain_q;
  logic [15:0] pulse_offset_q;

  scfd_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = scfd_pkg::reg_idx_e'(paddr[scfd_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= scfd_pkg::START_MARKER_RST;
      end_marker_q   <= scfd_pkg::END_MARKER_RST;
      hunt_limit_q   <= scfd_pkg::HUNT_LIMIT_RST;
      ack_ok_q       <= scfd_pkg::ACK_OK_RST;
      ack_fail_q     <= scfd_pkg::ACK_FAIL_RST;
      max_angle_q    <= scfd_pkg::MAX_ANGLE_RST;
      pulse_gain_q   <= scfd_pkg::PULSE_GAIN_RST;
      pulse_offset_q <= scfd_pkg::PULSE_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        scfd_pkg::REG_START_MARKER: start_marker_q <= pwdata[7:0];
        scfd_pkg::REG_END_MARKER:   end_marker_q   <= pwdata[7:0];
        scfd_pkg::REG_HUNT_LIMIT:   hunt_limit_q   <= pwdata[15:0];
        scfd_pkg::REG_ACK_OK:       ack_ok_q       <= pwdata[7:0];
        scfd_pkg::REG_ACK_FAIL:     ack_fail_q     <= pwdata[7:0];
        scfd_pkg::REG_MAX_ANGLE:    max_angle_q    <= pwdata[15:0];
        scfd_pkg::REG_PULSE_GAIN:   pulse_gain_q   <= pwdata[7:0];
        scfd_pkg::REG_PULSE_OFFSET: pulse_offset_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scfd_pkg::REG_START_MARKER: prdata = {24'd0, start_marker_q};
      scfd_pkg::REG_END_MARKER:   prdata = {24'd0, end_marker_q};
      scfd_pkg::REG_HUNT_LIMIT:   prdata = {16'd0, hunt_limit_q};
      scfd_pkg::REG_ACK_OK:       prdata = {24'd0, ack_ok_q};
      scfd_pkg::REG_ACK_FAIL:     prdata = {24'd0, ack_fail_q};
      scfd_pkg::REG_MAX_ANGLE:    prdata = {16'd0, max_angle_q};
      scfd_pkg::REG_PULSE_GAIN:   prdata = {24'd0, pulse_gain_q};
      scfd_pkg::REG_PULSE_OFFSET: prdata = {16'd0, pulse_offset_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // frame state
  scfd_pkg::phase_e phase_q, phase_d;
  logic [15:0]      hunt_count_q;
  logic [7:0]       servo_q;
  logic [7:0]       angle_hi_q;
  logic [7:0]       angle_lo_q;
  logic [7:0]       check_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       reply_byte_q;
  logic             accepted_q;
  scfd_pkg::cause_e fail_cause_q;
  logic [2:0]       servo_index_q;
  logic [15:0]      pulse_width_q;

  logic             in_fire;
  logic             is_start;
  logic [16:0]      hunt_inc;
  logic [7:0]       sum;
  logic [15:0]      angle;
  logic [23:0]      product;
  logic [24:0]      pulse_sum;
  logic [15:0]      pulse_sat;
  logic             out_of_range;

  logic             res_valid;
  logic             res_ok;
  scfd_pkg::cause_e res_cause;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_start   = (rx_byte_i == start_marker_q);
  assign hunt_inc   = {1'b0, hunt_count_q} + 17'd1;

  assign sum          = start_marker_q + servo_q + angle_hi_q + angle_lo_q;
  assign angle        = {angle_hi_q, angle_lo_q};
  assign product      = pulse_gain_q * angle;
  assign pulse_sum    = {1'b0, product} + {9'd0, pulse_offset_q};
  assign pulse_sat    = (|pulse_sum[24:16]) ? 16'hFFFF : pulse_sum[15:0];
  assign out_of_range = (servo_q == 8'd0) || (servo_q > 8'(scfd_pkg::SERVO_COUNT))
                        || (angle > max_angle_q);

  // next phase
  always_comb begin
    unique case (phase_q)
      scfd_pkg::PHASE_SERVO: phase_d = scfd_pkg::PHASE_HIGH;
      scfd_pkg::PHASE_HIGH:  phase_d = scfd_pkg::PHASE_LOW;
      scfd_pkg::PHASE_LOW:   phase_d = scfd_pkg::PHASE_CHECK;
      scfd_pkg::PHASE_CHECK: phase_d = scfd_pkg::PHASE_END;
      scfd_pkg::PHASE_END:   phase_d = scfd_pkg::PHASE_HUNT;
      default:               phase_d = is_start ? scfd_pkg::PHASE_SERVO
                                                : scfd_pkg::PHASE_HUNT;
    endcase
  end

  // result decode
  always_comb begin
    res_valid = 1'b0;
    res_ok    = 1'b0;
    res_cause = scfd_pkg::CAUSE_NONE;
    unique case (phase_q)
      scfd_pkg::PHASE_SERVO, scfd_pkg::PHASE_HIGH,
      scfd_pkg::PHASE_LOW, scfd_pkg::PHASE_CHECK: begin
        res_valid = 1'b0;
      end
      scfd_pkg::PHASE_END: begin
        res_valid = 1'b1;
        if (rx_byte_i != end_marker_q) begin
          res_cause = scfd_pkg::CAUSE_BAD_END;
        end else if (sum != check_q) begin
          res_cause = scfd_pkg::CAUSE_BAD_CHECK;
        end else if (out_of_range) begin
          res_cause = scfd_pkg::CAUSE_RANGE;
        end else begin
          res_ok = 1'b1;
        end
      end
      default: begin
        if (!is_start && (hunt_inc > {1'b0, hunt_limit_q})) begin
          res_valid = 1'b1;
          res_cause = scfd_pkg::CAUSE_TIMEOUT;
        end
      end
    endcase
  end

  always_comb begin
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= scfd_pkg::PHASE_HUNT;
      hunt_count_q <= 16'd0;
      servo_q      <= 8'd0;
      angle_hi_q   <= 8'd0;
      angle_lo_q   <= 8'd0;
      check_q      <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        if (res_valid) begin
          hunt_count_q <= 16'd0;
        end else if (phase_q == scfd_pkg::PHASE_HUNT && !is_start) begin
          hunt_count_q <= hunt_inc[15:0];
        end
        if (phase_q == scfd_pkg::PHASE_SERVO) servo_q    <= rx_byte_i;
        if (phase_q == scfd_pkg::PHASE_HIGH)  angle_hi_q <= rx_byte_i;
        if (phase_q == scfd_pkg::PHASE_LOW)   angle_lo_q <= rx_byte_i;
        if (phase_q == scfd_pkg::PHASE_CHECK) check_q    <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      reply_byte_q  <= res_ok ? ack_ok_q : ack_fail_q;
      accepted_q    <= res_ok;
      fail_cause_q  <= res_cause;
      servo_index_q <= res_ok ? servo_q[2:0] : 3'd0;
      pulse_width_q <= res_ok ? pulse_sat : 16'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reply_byte_o  = reply_byte_q;
  assign accepted_o    = accepted_q;
  assign fail_cause_o  = fail_cause_q;
  assign servo_index_o = servo_index_q;
  assign pulse_width_o = pulse_width_q;

  // accepted commands address a real servo and carry no cause
  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> fail_cause_o == scfd_pkg::CAUSE_NONE
      && servo_index_o != 3'd0 && servo_index_o <= 3'(scfd_pkg::SERVO_COUNT))
    else $error("accepted reply with bad cause or servo");

  // failures carry a cause and zero payload
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> fail_cause_o != scfd_pkg::CAUSE_NONE
      && servo_index_o == 3'd0 && pulse_width_o == 16'd0)
    else $error("failed reply with bad fields");

  // a new reply follows a taken byte
  a_reply_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire && res_valid))
    else $error("reply without a causing item");

  // every reply restarts the hunt with a clear count
  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_valid |=> phase_q == scfd_pkg::PHASE_HUNT && hunt_count_q == 16'd0)
    else $error("hunt not restarted after reply");

  // only the start marker leaves the hunt
  a_hunt_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == scfd_pkg::PHASE_HUNT && !is_start |=>
      phase_q == scfd_pkg::PHASE_HUNT)
    else $error("hunt left without start marker");

endmodule
